@@ rtl/gno_pkg.sv @@
// ----------------------------------------------------------------------------
// gno_pkg: shared types and constants for the gradient noise core
// Transaction kind codes, configuration register indexes, reset values and
// fixed datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gno_pkg;

    localparam int KIND_W   = 2;
    localparam int PERM_W   = 8;
    localparam int GRAD_W   = 16;
    localparam int COORD_W  = 32;
    localparam int CFG_W    = 16;
    localparam int FADE_W   = 17;
    localparam int Q_W      = 21;
    localparam int DOT_W    = 35;
    localparam int MUL_A_W  = 37;
    localparam int MUL_B_W  = 18;
    localparam int MUL_P_W  = 55;
    localparam int QUO_W    = 16;

    localparam logic [KIND_W-1:0] KIND_PERM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GRAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVAL = 2'd2;

    localparam logic [1:0] CFG_DIMENSIONS  = 2'd0;
    localparam logic [1:0] CFG_OCTAVES     = 2'd1;
    localparam logic [1:0] CFG_PERSISTENCE = 2'd2;

    localparam logic [1:0]  DIM_RESET  = 2'd3;
    localparam logic [3:0]  OCT_RESET  = 4'd1;
    localparam logic [15:0] PERS_RESET = 16'd32768;

    localparam logic [16:0] AMP_ONE = 17'd65536;
    localparam logic signed [MUL_A_W-1:0] NOISE_BIAS = 37'sd2147483648;

    typedef struct packed {
        logic [GRAD_W-1:0] z;
        logic [GRAD_W-1:0] y;
        logic [GRAD_W-1:0] x;
    } grad_t;

endpackage

`default_nettype wire

@@ rtl/gno_ram.sv @@
// ----------------------------------------------------------------------------
// gno_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gno_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/gradient_noise_octaves_core.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_octaves_core: fractal gradient noise, 1 to 3 axes
// Loads fill the permutation and gradient RAMs; an evaluate transaction
// runs all octaves on one shared multiplier and returns unsigned Q0.16.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_write            cfg_index, cfg_data
//   in       in   in_valid / in_ready  kind, table_index, perm_value,
//                                      grad_x/y/z, coord_x/y/z
//   out      out  out_valid / out_ready noise_value
//
// Loads leave the core idle and ready for the next transaction. An
// evaluate's time to out_valid grows with axes and octaves, set by the
// single multiplier and the registered permutation reads, and is shorter
// when the result is zero or saturates. Reset clears the sequencer and
// the output flag, sets configuration to its reset values and leaves the
// RAMs uncleared. in_ready is low during an evaluate; a result waiting on
// out_ready holds the sequencer only at its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_octaves_core #(
    parameter int TABLE_SIZE  = 256,
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [gno_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [gno_pkg::KIND_W-1:0]  kind,
    input  wire logic [7:0]                  table_index,
    input  wire logic [gno_pkg::PERM_W-1:0]  perm_value,
    input  wire logic signed [15:0]          grad_x,
    input  wire logic signed [15:0]          grad_y,
    input  wire logic signed [15:0]          grad_z,
    input  wire logic signed [31:0]          coord_x,
    input  wire logic signed [31:0]          coord_y,
    input  wire logic signed [31:0]          coord_z,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [15:0]                      noise_value
);

    localparam int AW    = $clog2(TABLE_SIZE);
    localparam int SW    = FRAC_BITS + AW;
    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int WS_W  = 18 + $clog2(MAX_OCTAVES);
    localparam int TOT_W = 55 + $clog2(MAX_OCTAVES);
    localparam int DOT_W = gno_pkg::DOT_W;
    localparam int MA_W  = gno_pkg::MUL_A_W;
    localparam int MB_W  = gno_pkg::MUL_B_W;
    localparam int MP_W  = gno_pkg::MUL_P_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FADE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_HWAIT  = 4'd3;
    localparam logic [3:0] S_GRAD   = 4'd4;
    localparam logic [3:0] S_DOT    = 4'd5;
    localparam logic [3:0] S_LERP   = 4'd6;
    localparam logic [3:0] S_NOISE  = 4'd7;
    localparam logic [3:0] S_AMP    = 4'd8;
    localparam logic [3:0] S_DIVCHK = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    // control
    logic [3:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  dimensions_reg;
    logic [3:0]  octave_count_reg;
    logic [15:0] persistence_reg;

    // datapath
    logic [1:0]          dims_reg, dims_next;
    logic [OCT_W-1:0]    octs_reg, octs_next;
    logic [OCT_W-1:0]    oct_reg, oct_next;
    logic [SW-1:0]       sc_reg [3];
    logic [SW-1:0]       sc_next [3];
    logic [16:0]         fade_reg [3];
    logic [16:0]         fade_next [3];
    logic [1:0]          fstep_reg, fstep_next;
    logic [1:0]          ax_reg, ax_next;
    logic [2:0]          corner_reg, corner_next;
    logic [AW-1:0]       h_reg, h_next;
    logic signed [DOT_W-1:0] acc_reg, acc_next;
    logic signed [DOT_W-1:0] dq_reg [8];
    logic signed [DOT_W-1:0] dq_next [8];
    logic [3:0]          cnt_reg, cnt_next;
    logic [2:0]          lleft_reg, lleft_next;
    logic [1:0]          lax_reg, lax_next;
    logic [16:0]         t2_reg, t2_next;
    logic [16:0]         t3_reg, t3_next;
    logic [gno_pkg::Q_W-1:0] q_reg, q_next;
    logic [16:0]         amp_reg, amp_next;
    logic [WS_W-1:0]     wsum_reg, wsum_next;
    logic signed [TOT_W-1:0] total_reg, total_next;
    logic [TOT_W-1:0]    rem_reg, rem_next;
    logic [TOT_W-1:0]    dsh_reg, dsh_next;
    logic [gno_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [3:0]          step_reg, step_next;
    logic [15:0]         res_reg, res_next;
    logic [15:0]         noise_value_reg, noise_value_next;

    // shared multiplier
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;

    // helpers
    logic [SW-1:0]           sc_sel;
    logic [FRAC_BITS+15:0]   frac_wide;
    logic [15:0]             frac_sel;
    logic [AW-1:0]           cell_sel;
    logic [1:0]              last_ax;
    logic [2:0]              last_corner;
    logic [AW-1:0]           hash_addr;
    logic signed [17:0]      off_sel;
    logic signed [15:0]      grad_sel;
    logic [22:0]             q_full;
    logic signed [MA_W-1:0]  noise_sum;
    logic signed [MA_W-1:0]  noise_val;
    logic signed [DOT_W-1:0] acc_sum;
    logic signed [DOT_W-1:0] lerp_res;
    logic [2:0]              wr_idx;
    logic                    div_ge;

    logic                    in_fire;
    logic [gno_pkg::PERM_W-1:0] perm_rd;
    gno_pkg::grad_t          grad_wr;
    gno_pkg::grad_t          grad_rd;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign noise_value = noise_value_reg;

    assign grad_wr.x = grad_x;
    assign grad_wr.y = grad_y;
    assign grad_wr.z = grad_z;

    gno_ram #(
        .WIDTH (gno_pkg::PERM_W),
        .DEPTH (TABLE_SIZE)
    ) u_perm_ram (
        .clk     (clk),
        .wr_en   (in_fire && (kind == gno_pkg::KIND_PERM)),
        .wr_addr (AW'(table_index)),
        .wr_data (perm_value),
        .rd_en   (state_reg == S_HASH),
        .rd_addr (hash_addr),
        .rd_data (perm_rd)
    );

    gno_ram #(
        .WIDTH ($bits(gno_pkg::grad_t)),
        .DEPTH (TABLE_SIZE)
    ) u_grad_ram (
        .clk     (clk),
        .wr_en   (in_fire && (kind == gno_pkg::KIND_GRAD)),
        .wr_addr (AW'(table_index)),
        .wr_data (grad_wr),
        .rd_en   (state_reg == S_GRAD),
        .rd_addr (h_reg),
        .rd_data (grad_rd)
    );

    assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

    always_comb
    begin
        sc_sel      = sc_reg[ax_reg];
        frac_wide   = {sc_sel[FRAC_BITS-1:0], 16'd0} >> FRAC_BITS;
        frac_sel    = frac_wide[15:0];
        cell_sel    = sc_sel[SW-1:FRAC_BITS];
        last_ax     = dims_reg - 2'd1;
        last_corner = 3'((4'd1 << dims_reg) - 4'd1);
        hash_addr   = cell_sel + AW'(corner_reg[ax_reg])
                      + ((ax_reg == last_ax) ? {AW{1'b0}} : h_reg);
        off_sel     = $signed({2'b00, frac_sel})
                      - (corner_reg[ax_reg] ? 18'sd65536 : 18'sd0);
        case (ax_reg)
            2'd0:    grad_sel = $signed(grad_rd.x);
            2'd1:    grad_sel = $signed(grad_rd.y);
            default: grad_sel = $signed(grad_rd.z);
        endcase
        q_full    = 23'(t2_reg) * 23'd6 - 23'(frac_sel) * 23'd15 + 23'd655360;
        noise_sum = MA_W'(dq_reg[0]) + gno_pkg::NOISE_BIAS;
        noise_val = noise_sum >>> 1;
        acc_sum   = acc_reg + DOT_W'(mul_p);
        lerp_res  = dq_reg[0] + DOT_W'(mul_p >>> 16);
        wr_idx    = 3'(cnt_reg - 4'd2);
        div_ge    = (rem_reg >= dsh_reg);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_FADE:
            begin
                case (fstep_reg)
                    2'd0:
                    begin
                        mul_a = MA_W'($signed({1'b0, frac_sel}));
                        mul_b = MB_W'($signed({1'b0, frac_sel}));
                    end
                    2'd1:
                    begin
                        mul_a = MA_W'($signed({1'b0, t2_reg}));
                        mul_b = MB_W'($signed({1'b0, frac_sel}));
                    end
                    default:
                    begin
                        mul_a = MA_W'($signed({1'b0, q_reg}));
                        mul_b = $signed({1'b0, t3_reg});
                    end
                endcase
            end
            S_DOT:
            begin
                mul_a = MA_W'(off_sel);
                mul_b = MB_W'(grad_sel);
            end
            S_LERP:
            begin
                mul_a = MA_W'(dq_reg[1]) - MA_W'(dq_reg[0]);
                mul_b = $signed({1'b0, fade_reg[lax_reg]});
            end
            S_NOISE:
            begin
                mul_a = noise_val;
                mul_b = $signed({1'b0, amp_reg});
            end
            S_AMP:
            begin
                mul_a = MA_W'($signed({1'b0, persistence_reg}));
                mul_b = $signed({1'b0, amp_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        dims_next        = dims_reg;
        octs_next        = octs_reg;
        oct_next         = oct_reg;
        sc_next          = sc_reg;
        fade_next        = fade_reg;
        fstep_next       = fstep_reg;
        ax_next          = ax_reg;
        corner_next      = corner_reg;
        h_next           = h_reg;
        acc_next         = acc_reg;
        dq_next          = dq_reg;
        cnt_next         = cnt_reg;
        lleft_next       = lleft_reg;
        lax_next         = lax_reg;
        t2_next          = t2_reg;
        t3_next          = t3_reg;
        q_next           = q_reg;
        amp_next         = amp_reg;
        wsum_next        = wsum_reg;
        total_next       = total_reg;
        rem_next         = rem_reg;
        dsh_next         = dsh_reg;
        quo_next         = quo_reg;
        step_next        = step_reg;
        res_next         = res_reg;
        noise_value_next = noise_value_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (kind == gno_pkg::KIND_EVAL))
                begin
                    dims_next = (dimensions_reg == 2'd0) ? 2'd1 : dimensions_reg;
                    if (octave_count_reg == 4'd0)
                    begin
                        octs_next = OCT_W'(1);
                    end
                    else if (32'(octave_count_reg) > MAX_OCTAVES)
                    begin
                        octs_next = OCT_W'(MAX_OCTAVES);
                    end
                    else
                    begin
                        octs_next = OCT_W'(octave_count_reg);
                    end
                    sc_next[0] = SW'(coord_x);
                    sc_next[1] = SW'(coord_y);
                    sc_next[2] = SW'(coord_z);
                    oct_next   = '0;
                    total_next = '0;
                    wsum_next  = '0;
                    amp_next   = gno_pkg::AMP_ONE;
                    ax_next    = 2'd0;
                    fstep_next = 2'd0;
                    state_next = S_FADE;
                end
            end
            S_FADE:
            begin
                case (fstep_reg)
                    2'd0:
                    begin
                        t2_next    = mul_p[32:16];
                        fstep_next = 2'd1;
                    end
                    2'd1:
                    begin
                        t3_next    = mul_p[32:16];
                        q_next     = q_full[gno_pkg::Q_W-1:0];
                        fstep_next = 2'd2;
                    end
                    default:
                    begin
                        fade_next[ax_reg] = mul_p[32:16];
                        fstep_next        = 2'd0;
                        if (ax_reg == last_ax)
                        begin
                            corner_next = 3'd0;
                            cnt_next    = 4'd0;
                            state_next  = S_HASH;
                        end
                        else
                        begin
                            ax_next = ax_reg + 2'd1;
                        end
                    end
                endcase
            end
            S_HASH:
            begin
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                h_next = AW'(perm_rd);
                if (ax_reg == 2'd0)
                begin
                    state_next = S_GRAD;
                end
                else
                begin
                    ax_next    = ax_reg - 2'd1;
                    state_next = S_HASH;
                end
            end
            S_GRAD:
            begin
                ax_next    = 2'd0;
                acc_next   = '0;
                state_next = S_DOT;
            end
            S_DOT:
            begin
                if (ax_reg == last_ax)
                begin
                    dq_next[cnt_reg[2:0]] = acc_sum;
                    cnt_next = cnt_reg + 4'd1;
                    if (corner_reg == last_corner)
                    begin
                        lax_next   = 2'd0;
                        lleft_next = 3'((4'd1 << dims_reg) >> 1);
                        state_next = S_LERP;
                    end
                    else
                    begin
                        corner_next = corner_reg + 3'd1;
                        state_next  = S_HASH;
                    end
                end
                else
                begin
                    acc_next = acc_sum;
                    ax_next  = ax_reg + 2'd1;
                end
            end
            S_LERP:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    dq_next[i] = dq_reg[i + 2];
                end
                dq_next[wr_idx] = lerp_res;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd2)
                begin
                    state_next = S_NOISE;
                end
                else if (lleft_reg == 3'd1)
                begin
                    lax_next   = lax_reg + 2'd1;
                    lleft_next = 3'((4'd1 << dims_reg) >> ({1'b0, lax_reg} + 3'd2));
                end
                else
                begin
                    lleft_next = lleft_reg - 3'd1;
                end
            end
            S_NOISE:
            begin
                total_next = total_reg + TOT_W'(mul_p);
                wsum_next  = wsum_reg + WS_W'(amp_reg);
                state_next = S_AMP;
            end
            S_AMP:
            begin
                amp_next = mul_p[32:16];
                if (oct_reg == octs_reg - OCT_W'(1))
                begin
                    state_next = S_DIVCHK;
                end
                else
                begin
                    oct_next = oct_reg + OCT_W'(1);
                    for (int i = 0; i < 3; i++)
                    begin
                        sc_next[i] = {sc_reg[i][SW-2:0], 1'b0};
                    end
                    ax_next    = 2'd0;
                    fstep_next = 2'd0;
                    state_next = S_FADE;
                end
            end
            S_DIVCHK:
            begin
                if (total_reg[TOT_W-1])
                begin
                    res_next   = 16'd0;
                    state_next = S_FIN;
                end
                else if ($unsigned(total_reg) >= TOT_W'({wsum_reg, 31'd0}))
                begin
                    res_next   = 16'hFFFF;
                    state_next = S_FIN;
                end
                else
                begin
                    rem_next   = $unsigned(total_reg);
                    dsh_next   = TOT_W'({wsum_reg, 30'd0});
                    quo_next   = '0;
                    step_next  = 4'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next  = dsh_reg >> 1;
                quo_next  = {quo_reg[gno_pkg::QUO_W-2:0], div_ge};
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    res_next   = {quo_reg[gno_pkg::QUO_W-2:0], div_ge};
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    noise_value_next = res_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            dimensions_reg   <= gno_pkg::DIM_RESET;
            octave_count_reg <= gno_pkg::OCT_RESET;
            persistence_reg  <= gno_pkg::PERS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    gno_pkg::CFG_DIMENSIONS:  dimensions_reg   <= cfg_data[1:0];
                    gno_pkg::CFG_OCTAVES:     octave_count_reg <= cfg_data[3:0];
                    gno_pkg::CFG_PERSISTENCE: persistence_reg  <= cfg_data;
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dims_reg        <= dims_next;
        octs_reg        <= octs_next;
        oct_reg         <= oct_next;
        sc_reg          <= sc_next;
        fade_reg        <= fade_next;
        fstep_reg       <= fstep_next;
        ax_reg          <= ax_next;
        corner_reg      <= corner_next;
        h_reg           <= h_next;
        acc_reg         <= acc_next;
        dq_reg          <= dq_next;
        cnt_reg         <= cnt_next;
        lleft_reg       <= lleft_next;
        lax_reg         <= lax_next;
        t2_reg          <= t2_next;
        t3_reg          <= t3_next;
        q_reg           <= q_next;
        amp_reg         <= amp_next;
        wsum_reg        <= wsum_next;
        total_reg       <= total_next;
        rem_reg         <= rem_next;
        dsh_reg         <= dsh_next;
        quo_reg         <= quo_next;
        step_reg        <= step_next;
        res_reg         <= res_next;
        noise_value_reg <= noise_value_next;
    end

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && (!out_valid_reg || out_ready)
        |=> out_valid_reg && (noise_value == $past(res_reg)) && (state_reg == S_IDLE))
        else $error("finished result not delivered");

    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == gno_pkg::KIND_EVAL) |=> (state_reg == S_FADE))
        else $error("evaluate transaction did not start");

    a_lerp_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LERP) |-> (cnt_reg >= 4'd2) && (cnt_reg <= 4'd8))
        else $error("corner queue underflow in blend");

    a_div_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !total_reg[TOT_W-1] && (dsh_reg != '0))
        else $error("division entered with bad operands");

endmodule

`default_nettype wire
